// ===== rtl/dcfe_pkg.sv =====
// Package for the DMA copy and fill engine.
// Holds the request, register, job and status codes, the address limits and the
// sequencer state type. It has no dependencies.
package dcfe_pkg;

  typedef enum logic [1:0] {
    REQ_DMA_REG = 2'd0,
    REQ_MEM_WR  = 2'd1,
    REQ_MEM_RD  = 2'd2
  } req_cmd_t;

  typedef enum logic [1:0] {
    OFF_START = 2'd0,
    OFF_HIGH  = 2'd1,
    OFF_BANK  = 2'd2
  } dma_off_t;

  typedef enum logic [2:0] {
    STATUS_NONE        = 3'd0,
    STATUS_COPY_DONE   = 3'd1,
    STATUS_FILL_DONE   = 3'd2,
    STATUS_FILL_REJECT = 3'd3,
    STATUS_UNKNOWN     = 3'd4
  } job_status_t;

  localparam logic [7:0] JOB_COPY = 8'd0;
  localparam logic [7:0] JOB_FILL = 8'd3;

  localparam int unsigned REC_BYTES = 11;
  localparam logic [3:0]  REC_LAST  = 4'd10;

  localparam logic [23:0] LIMIT_1M    = 24'h100000;
  localparam logic [23:0] LOW_RAM_END = 24'h020000;
  localparam logic [23:0] EXP_START   = 24'h080000;

  localparam logic [2:0] CFG_EXPANSION_ADDR = 3'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEM_RD,
    ST_REC_RD,
    ST_REC_CAP,
    ST_DECODE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FILL,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/dcfe_stream_if.sv =====
// Valid/ready channel interfaces for the DMA copy and fill engine.
// dcfe_req_if carries requests, dcfe_rsp_if carries results. No dependencies.
interface dcfe_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [19:0] mem_address;
  logic [1:0]  dma_offset;
  logic [7:0]  data_byte;

  modport source (output valid, cmd, mem_address, dma_offset, data_byte, input ready);
  modport sink (input valid, cmd, mem_address, dma_offset, data_byte, output ready);
endinterface

interface dcfe_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [2:0]  job_status;
  logic [15:0] bytes_moved;

  modport source (output valid, read_data, job_status, bytes_moved, input ready);
  modport sink (input valid, read_data, job_status, bytes_moved, output ready);
endinterface

// ===== rtl/dcfe_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Used for the engine's byte memory. No dependencies.
module dcfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dma_copy_fill_engine_unit.sv =====
// Top level of the DMA copy and fill engine with its own byte memory.
// Depends on dcfe_pkg, dcfe_stream_if and dcfe_ram.
//
// Requests arrive on the req channel and exactly one result leaves on the rsp
// channel for each request; a transfer happens when valid and ready are high.
// A request is a memory write, a memory read or a DMA register write; a write
// to register offset 0 starts a job whose 11-byte record is read from memory.
// One request is handled at a time, and req.ready stays low from acceptance
// until its result has been taken.
// Sequence: a memory write or a register write that starts no job goes straight
// to ST_RESP, a memory read passes through ST_MEM_RD first. A job reads its
// record byte by byte (ST_REC_RD, ST_REC_CAP), decodes it in ST_DECODE, then a
// copy reads then writes each byte of the single RAM (ST_COPY_RD, ST_COPY_WR)
// and a fill writes its bytes in ST_FILL, before the result goes out in ST_RESP.
// When the receiver stalls, the result is held in the output registers and
// no new request is taken. Reset clears the sequencer, the job address bytes
// and expansion_512k; the memory is not cleared and holds garbage until
// written. expansion_512k is written through the APB port at address 0.
module dma_copy_fill_engine_unit #(
  parameter int unsigned ADDR_BITS = 20
) (
  input  logic              clk,
  input  logic              rst,
  dcfe_req_if.sink          req,
  dcfe_rsp_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;

  dcfe_pkg::state_t state;
  dcfe_pkg::state_t state_next;

  logic                 expansion_512k;
  logic [7:0]           job_high_byte;
  logic [7:0]           job_bank_byte;

  logic [23:0]          job_base;
  logic [3:0]           rec_idx;
  logic [7:0]           rec [dcfe_pkg::REC_BYTES];
  logic [23:0]          src;
  logic [23:0]          dst;
  logic [15:0]          remain;

  logic [7:0]           read_data;
  logic [2:0]           job_status;
  logic [15:0]          bytes_moved;

  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  logic [7:0]           ram_wdata;
  logic                 ram_re;
  logic [ADDR_BITS-1:0] ram_raddr;
  logic [7:0]           ram_rdata;

  logic                 req_fire;
  logic [23:0]          rec_addr;
  logic [15:0]          rec_len;
  logic [23:0]          rec_src;
  logic [23:0]          rec_dst;
  logic                 fill_over;
  logic                 dst_ok;
  logic                 copy_stop;
  logic                 fill_stop;

  function automatic logic allowed(input logic [23:0] d, input logic exp_en);
    logic ok;
    ok = (d < dcfe_pkg::LOW_RAM_END) ||
         (exp_en && d >= dcfe_pkg::EXP_START && d < dcfe_pkg::LIMIT_1M);
    return ok;
  endfunction

  assign pready = 1'b1;
  assign prdata = {31'd0, expansion_512k};

  assign req.ready       = (state == dcfe_pkg::ST_IDLE);
  assign rsp.valid       = (state == dcfe_pkg::ST_RESP);
  assign rsp.read_data   = read_data;
  assign rsp.job_status  = job_status;
  assign rsp.bytes_moved = bytes_moved;

  assign req_fire  = req.valid && req.ready;
  assign rec_addr  = job_base + 24'(rec_idx);
  assign rec_len   = {rec[2], rec[1]};
  assign rec_src   = {rec[5], rec[4], rec[3]};
  assign rec_dst   = {rec[8], rec[7], rec[6]};
  assign fill_over = ({1'b0, rec_dst} + 25'(rec_len)) >= {1'b0, dcfe_pkg::LIMIT_1M};
  assign dst_ok    = allowed(dst, expansion_512k);
  assign copy_stop = (remain == 16'd0) || (dst >= dcfe_pkg::LIMIT_1M) ||
                     (src >= dcfe_pkg::LIMIT_1M) || !dst_ok;
  assign fill_stop = (remain == 16'd0) || !dst_ok;

  dcfe_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcfe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = dst[ADDR_BITS-1:0];
    ram_wdata  = rec[3];
    ram_re     = 1'b0;
    ram_raddr  = rec_addr[ADDR_BITS-1:0];
    unique case (state)
      dcfe_pkg::ST_IDLE: begin
        if (req_fire) begin
          state_next = dcfe_pkg::ST_RESP;
          if (req.cmd == dcfe_pkg::REQ_MEM_WR) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_BITS'(req.mem_address);
            ram_wdata = req.data_byte;
          end else if (req.cmd == dcfe_pkg::REQ_MEM_RD) begin
            ram_re     = 1'b1;
            ram_raddr  = ADDR_BITS'(req.mem_address);
            state_next = dcfe_pkg::ST_MEM_RD;
          end else if (req.cmd == dcfe_pkg::REQ_DMA_REG &&
                       req.dma_offset == dcfe_pkg::OFF_START) begin
            state_next = dcfe_pkg::ST_REC_RD;
          end
        end
      end
      dcfe_pkg::ST_MEM_RD: begin
        state_next = dcfe_pkg::ST_RESP;
      end
      dcfe_pkg::ST_REC_RD: begin
        ram_re     = 1'b1;
        state_next = dcfe_pkg::ST_REC_CAP;
      end
      dcfe_pkg::ST_REC_CAP: begin
        state_next = (rec_idx == dcfe_pkg::REC_LAST) ? dcfe_pkg::ST_DECODE
                                                     : dcfe_pkg::ST_REC_RD;
      end
      dcfe_pkg::ST_DECODE: begin
        if (rec[0] == dcfe_pkg::JOB_COPY) begin
          state_next = dcfe_pkg::ST_COPY_RD;
        end else if (rec[0] == dcfe_pkg::JOB_FILL && !fill_over) begin
          state_next = dcfe_pkg::ST_FILL;
        end else begin
          state_next = dcfe_pkg::ST_RESP;
        end
      end
      dcfe_pkg::ST_COPY_RD: begin
        if (copy_stop) begin
          state_next = dcfe_pkg::ST_RESP;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = src[ADDR_BITS-1:0];
          state_next = dcfe_pkg::ST_COPY_WR;
        end
      end
      dcfe_pkg::ST_COPY_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        state_next = dcfe_pkg::ST_COPY_RD;
      end
      dcfe_pkg::ST_FILL: begin
        if (fill_stop) begin
          state_next = dcfe_pkg::ST_RESP;
        end else begin
          ram_we = 1'b1;
        end
      end
      dcfe_pkg::ST_RESP: begin
        if (rsp.ready) begin
          state_next = dcfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dcfe_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expansion_512k <= 1'b0;
      job_high_byte  <= 8'd0;
      job_bank_byte  <= 8'd0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == dcfe_pkg::CFG_EXPANSION_ADDR) begin
        expansion_512k <= pwdata[0];
      end
      if (req_fire && req.cmd == dcfe_pkg::REQ_DMA_REG) begin
        if (req.dma_offset == dcfe_pkg::OFF_HIGH) begin
          job_high_byte <= req.data_byte;
        end else if (req.dma_offset == dcfe_pkg::OFF_BANK) begin
          job_bank_byte <= req.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dcfe_pkg::ST_IDLE: begin
        if (req_fire) begin
          read_data   <= 8'd0;
          job_status  <= dcfe_pkg::STATUS_NONE;
          bytes_moved <= 16'd0;
          job_base    <= {job_bank_byte, job_high_byte, req.data_byte};
          rec_idx     <= 4'd0;
        end
      end
      dcfe_pkg::ST_MEM_RD: begin
        read_data <= ram_rdata;
      end
      dcfe_pkg::ST_REC_RD: begin
      end
      dcfe_pkg::ST_REC_CAP: begin
        rec[rec_idx] <= ram_rdata;
        rec_idx      <= rec_idx + 4'd1;
      end
      dcfe_pkg::ST_DECODE: begin
        src    <= rec_src;
        dst    <= rec_dst;
        remain <= rec_len;
        if (rec[0] == dcfe_pkg::JOB_FILL) begin
          if (fill_over) begin
            job_status <= dcfe_pkg::STATUS_FILL_REJECT;
          end
        end else if (rec[0] != dcfe_pkg::JOB_COPY) begin
          job_status <= dcfe_pkg::STATUS_UNKNOWN;
        end
      end
      dcfe_pkg::ST_COPY_RD: begin
        if (copy_stop) begin
          job_status <= dcfe_pkg::STATUS_COPY_DONE;
        end
      end
      dcfe_pkg::ST_COPY_WR: begin
        src         <= src + 24'd1;
        dst         <= dst + 24'd1;
        remain      <= remain - 16'd1;
        bytes_moved <= bytes_moved + 16'd1;
      end
      dcfe_pkg::ST_FILL: begin
        if (fill_stop) begin
          job_status <= dcfe_pkg::STATUS_FILL_DONE;
        end else begin
          dst         <= dst + 24'd1;
          remain      <= remain - 16'd1;
          bytes_moved <= bytes_moved + 16'd1;
        end
      end
      dcfe_pkg::ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for dma_copy_fill_engine_unit: directed and random requests,
// with a behavioral prediction of the engine's memory, job registers and window setting.
// Depends on dcfe_pkg, dcfe_stream_if and the RTL top level.
module tb;
  import dcfe_pkg::*;

  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam logic [1:0] OFF_IGNORED = 2'd3;
  localparam int unsigned ADDR_MASK = 32'hFFFFF;
  localparam int unsigned REC_REGION = 32'h40000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  read_data;
    job_status_t job_status;
    logic [15:0] bytes_moved;
  } engine_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dcfe_req_if req();
  dcfe_rsp_if rsp();

  dma_copy_fill_engine_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [7:0]     ram_image [int];
  logic [7:0]     job_high_q = '0;
  logic [7:0]     job_bank_q = '0;
  logic           window_512k = 1'b0;
  engine_result_t pending_results [$];
  int unsigned    known_addrs [$];
  int             mismatch_count = 0;
  int             transfers_checked = 0;
  int             jobs_run = 0;
  int unsigned    src_idle_pct = 8;
  int unsigned    snk_stall_pct = 73;
  int unsigned    hold_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit dst_in_window(int unsigned d);
    return d < LOW_RAM_END || (window_512k && d >= EXP_START && d < LIMIT_1M);
  endfunction

  function automatic logic [7:0] ram_byte(int unsigned a);
    return ram_image.exists(a & ADDR_MASK) ? ram_image[a & ADDR_MASK] : 8'h00;
  endfunction

  function automatic int unsigned copy_reads(int unsigned s, int unsigned t, int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if (t + k >= LIMIT_1M || s + k >= LIMIT_1M || !dst_in_window(t + k)) break;
    end
    return k;
  endfunction

  function automatic engine_result_t engine_predict(logic [1:0] c, logic [19:0] a,
                                                    logic [1:0] o, logic [7:0] d);
    engine_result_t r;
    logic [7:0]     rec [REC_BYTES];
    int unsigned    base, n, s, t, moved, k;
    r = '0;
    moved = 0;
    case (c)
      REQ_MEM_WR: ram_image[a] = d;
      REQ_MEM_RD: r.read_data = ram_byte(a);
      REQ_DMA_REG: begin
        if (o == OFF_HIGH) begin
          job_high_q = d;
        end else if (o == OFF_BANK) begin
          job_bank_q = d;
        end else if (o == OFF_START) begin
          base = {job_bank_q, job_high_q, d};
          for (k = 0; k < REC_BYTES; k++) rec[k] = ram_byte(base + k);
          n = {rec[2], rec[1]};
          s = {rec[5], rec[4], rec[3]};
          t = {rec[8], rec[7], rec[6]};
          if (rec[0] == JOB_COPY) begin
            while (moved < n && t < LIMIT_1M && s < LIMIT_1M && dst_in_window(t)) begin
              ram_image[t] = ram_byte(s);
              t++;
              s++;
              moved++;
            end
            r.job_status = STATUS_COPY_DONE;
          end else if (rec[0] == JOB_FILL) begin
            if (t + n >= LIMIT_1M) begin
              r.job_status = STATUS_FILL_REJECT;
            end else begin
              while (moved < n && dst_in_window(t)) begin
                ram_image[t] = rec[3];
                t++;
                moved++;
              end
              r.job_status = STATUS_FILL_DONE;
            end
          end else begin
            r.job_status = STATUS_UNKNOWN;
          end
          r.bytes_moved = moved[15:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(logic [1:0] c, logic [19:0] a, logic [1:0] o, logic [7:0] d);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) @(negedge clk);
    req.valid       <= 1'b1;
    req.cmd         <= c;
    req.mem_address <= a;
    req.dma_offset  <= o;
    req.data_byte   <= d;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(engine_predict(c, a, o, d));
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window_cfg(logic value);
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_EXPANSION_ADDR;
    pwdata  <= {31'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    window_512k = value;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, value}) begin
      $error("expansion_512k: expected %0d, got %0d", value, prdata);
      mismatch_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_byte(int unsigned a, logic [7:0] d);
    send_item(REQ_MEM_WR, a[19:0], 2'($urandom), d);
    known_addrs.push_back(a & ADDR_MASK);
  endtask

  task automatic read_byte(int unsigned a);
    send_item(REQ_MEM_RD, a[19:0], 2'($urandom), 8'($urandom));
  endtask

  task automatic ensure_written(int unsigned s, int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if (!ram_image.exists((s + k) & ADDR_MASK)) write_byte(s + k, 8'($urandom));
    end
  endtask

  // The record is written first, then the address bytes that differ, then the start byte.
  task automatic run_job(int unsigned base, logic [7:0] op, int unsigned n,
                         int unsigned s, int unsigned t);
    logic [7:0]  rec [REC_BYTES];
    int unsigned k;
    rec = '{op, n[7:0], n[15:8], s[7:0], s[15:8], s[23:16], t[7:0], t[15:8], t[23:16],
            8'($urandom), 8'($urandom)};
    for (k = 0; k < REC_BYTES; k++) write_byte(base + k, rec[k]);
    if (job_bank_q != base[23:16]) send_item(REQ_DMA_REG, 20'($urandom), OFF_BANK, base[23:16]);
    if (job_high_q != base[15:8]) send_item(REQ_DMA_REG, 20'($urandom), OFF_HIGH, base[15:8]);
    send_item(REQ_DMA_REG, 20'($urandom), OFF_START, base[7:0]);
    jobs_run++;
  endtask

  task automatic test_mem_access();
    write_byte(0, 8'h00);
    write_byte(ADDR_MASK, 8'hFF);
    write_byte(32'hAAAAA, 8'h5A);
    write_byte(32'h55555, 8'hA5);
    read_byte(0);
    read_byte(ADDR_MASK);
    read_byte(32'hAAAAA);
    read_byte(32'h55555);
  endtask

  task automatic test_ignored_requests();
    send_item(REQ_IGNORED, 20'hFFFFF, 2'($urandom), 8'hFF);
    send_item(REQ_IGNORED, 20'($urandom), 2'($urandom), 8'($urandom));
    send_item(REQ_DMA_REG, 20'($urandom), OFF_IGNORED, 8'hFF);
  endtask

  task automatic test_copy_jobs();
    ensure_written(32'h100, 8);
    run_job(REC_REGION, JOB_COPY, 8, 32'h100, 32'h200);
    run_job(REC_REGION + 32'h10, JOB_COPY, 6, 32'h100, 32'h101);
    run_job(REC_REGION + 32'h20, JOB_COPY, 0, 32'h100, 32'h300);
    run_job(REC_REGION + 32'h30, JOB_COPY, 8, 32'h100, 32'h1FFFD);
    run_job(REC_REGION + 32'h40, JOB_COPY, 4, 32'h100, 32'hFFFFFF);
    ensure_written(32'hFFFFE, 2);
    run_job(REC_REGION + 32'h50, JOB_COPY, 4, 32'hFFFFE, 32'h400);
    read_byte(32'h207);
    read_byte(32'h106);
    read_byte(32'h1FFFF);
    read_byte(32'h401);
  endtask

  task automatic test_fill_jobs();
    run_job(REC_REGION + 32'h60, JOB_FILL, 5, 32'hA5, 32'h600);
    read_byte(32'h604);
    run_job(REC_REGION + 32'h70, JOB_FILL, 32'hFFFF, 32'h3C, 32'h1FFFC);
    run_job(REC_REGION + 32'h80, JOB_FILL, 32'h10, 32'h77, 32'hFFFF0);
    run_job(REC_REGION + 32'h90, JOB_FILL, 32'hF, 32'h77, 32'hFFFF0);
    run_job(REC_REGION + 32'hA0, 8'hFF, 4, 32'h100, 32'h800);
    run_job(REC_REGION + 32'hB0, 8'h01, 4, 32'h100, 32'h800);
  endtask

  task automatic test_job_address_wrap();
    run_job(32'hFFFFFA, JOB_FILL, 3, 32'h3C, 32'h700);
    run_job(32'h140040, JOB_COPY, 2, 32'h100, 32'h710);
    read_byte(32'h702);
    read_byte(32'h711);
  endtask

  task automatic test_expansion_window();
    write_window_cfg(1'b1);
    run_job(REC_REGION + 32'hC0, JOB_FILL, 4, 32'h99, 32'h7FFFE);
    run_job(REC_REGION + 32'hD0, JOB_FILL, 32'hF, 32'h99, 32'hFFFF0);
    run_job(REC_REGION + 32'hE0, JOB_COPY, 8, 32'h100, 32'h7FFFC);
    run_job(REC_REGION + 32'hF0, JOB_COPY, 8, 32'h100, 32'h80000);
    run_job(REC_REGION + 32'h100, JOB_COPY, 8, 32'h100, 32'hFFFFC);
    read_byte(32'hFFFFE);
    read_byte(32'h80007);
    write_window_cfg(1'b0);
    run_job(REC_REGION + 32'h110, JOB_COPY, 2, 32'h100, 32'h80000);
  endtask

  // The receiver refuses results for a long stretch while requests keep coming.
  task automatic test_backpressure();
    int unsigned k;
    hold_cycles = HOLD_OFF_CYCLES;
    for (k = 0; k < 6; k++) begin
      if (k[0]) read_byte(known_addrs[$urandom_range(0, known_addrs.size() - 1)]);
      else write_byte($urandom_range(0, ADDR_MASK), 8'($urandom));
    end
  endtask

  task automatic random_job();
    int unsigned base, n, s, t, pick;
    logic [7:0]  op;
    base = {4'($urandom), 20'(REC_REGION + $urandom_range(0, 32'hFFF0))};
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      op = JOB_COPY;
    end else if (pick < 90) begin
      op = JOB_FILL;
    end else begin
      do op = 8'($urandom); while (op == JOB_COPY || op == JOB_FILL);
    end
    pick = $urandom_range(0, 99);
    if (pick < 10) n = 0;
    else if (pick < 75) n = $urandom_range(1, 12);
    else if (pick < 90) n = $urandom_range(13, 48);
    else n = $urandom_range(32'h8000, 32'hFFFF);
    pick = (n > 48) ? 2 * $urandom_range(0, 2) + 1 : $urandom_range(0, 6);
    case (pick)
      1: t = LOW_RAM_END - $urandom_range(1, 16);
      2: t = EXP_START - 4 + $urandom_range(0, 8);
      3: t = LIMIT_1M - $urandom_range(1, 20);
      4: t = $urandom_range(LOW_RAM_END, EXP_START - 1);
      5: t = $urandom_range(LIMIT_1M, 32'hFFFFFF);
      default: t = $urandom_range(0, LOW_RAM_END - 1);
    endcase
    if (op == JOB_COPY) begin
      s = $urandom_range(0, 99);
      if (pick == 6) begin
        s = $urandom_range(0, 32'h1FF00);
        t = s + $urandom_range(1, 3);
      end else if (s < 50) begin
        s = known_addrs[$urandom_range(0, known_addrs.size() - 1)];
      end else if (s < 75) begin
        s = $urandom_range(0, LOW_RAM_END - 1);
      end else if (s < 90) begin
        s = LIMIT_1M - $urandom_range(1, 8);
      end else begin
        s = $urandom_range(LIMIT_1M, 32'hFFFFFF);
      end
      ensure_written(s, copy_reads(s, t, n));
    end else begin
      s = $urandom & 32'hFFFFFF;
    end
    run_job(base, op, n, s, t);
    if ($urandom_range(0, 3) == 0) begin
      send_item(REQ_DMA_REG, 20'($urandom), OFF_START, base[7:0]);
      jobs_run++;
    end
  endtask

  task automatic test_random(logic wide_window, int unsigned idle_pct, int unsigned stall_pct);
    int unsigned pick, k;
    write_window_cfg(wide_window);
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    for (k = 0; k < 6; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        random_job();
      end else if (pick < 85) begin
        write_byte($urandom_range(0, ADDR_MASK), 8'($urandom));
        read_byte(known_addrs[$urandom_range(0, known_addrs.size() - 1)]);
      end else if (pick < 90) begin
        send_item(REQ_DMA_REG, 20'($urandom), OFF_IGNORED, 8'($urandom));
      end else if (pick < 95) begin
        send_item(REQ_IGNORED, 20'($urandom), 2'($urandom), 8'($urandom));
      end else begin
        send_item(REQ_DMA_REG, 20'($urandom), $urandom_range(0, 1) ? OFF_HIGH : OFF_BANK,
                  8'($urandom));
      end
    end
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  // Every result transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    engine_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no prediction waiting");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        transfers_checked++;
        if (rsp.read_data !== want.read_data) begin
          $error("read_data: expected %0d, got %0d", want.read_data, rsp.read_data);
          mismatch_count++;
        end
        if (rsp.job_status !== want.job_status) begin
          $error("job_status: expected %0d, got %0d", want.job_status, rsp.job_status);
          mismatch_count++;
        end
        if (rsp.bytes_moved !== want.bytes_moved) begin
          $error("bytes_moved: expected %0d, got %0d", want.bytes_moved, rsp.bytes_moved);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("dma_copy_fill_engine_unit test failed");
    $finish;
  end

  initial begin
    req.valid       = 1'b0;
    req.cmd         = REQ_DMA_REG;
    req.mem_address = '0;
    req.dma_offset  = OFF_START;
    req.data_byte   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_window_cfg(1'b0);
    test_mem_access();
    test_ignored_requests();
    test_copy_jobs();
    test_fill_jobs();
    test_job_address_wrap();
    test_expansion_window();
    test_backpressure();
    test_random(1'b1, 8, 73);
    test_random(1'b0, 73, 8);
    test_random(1'b1, 0, 0);
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Checked %0d result transfers covering %0d copy, fill and unknown jobs,",
             transfers_checked, jobs_run);
    $display("with both window settings, three flow-control mixes and a long receiver stall.");
    if (mismatch_count == 0) begin
      $display("dma_copy_fill_engine_unit test passed");
    end else begin
      $display("dma_copy_fill_engine_unit test failed");
    end
    $finish;
  end

endmodule
